>>> hw/rtl/bsra_pkg.sv
// Shared types, codes and sizes for the single-resource banker's allocator.
package bsra_pkg;

  localparam int THREAD_SLOTS   = 8;
  localparam int UNIT_BITS      = 8;
  localparam int TID_BITS       = 3;
  localparam int THREADS_BITS   = 4;
  localparam int WORK_BITS      = UNIT_BITS + TID_BITS;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 2;

  // command codes
  localparam logic [1:0] CMD_REQUEST  = 2'd0;
  localparam logic [1:0] CMD_RELEASE  = 2'd1;
  localparam logic [1:0] CMD_SHUTDOWN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THREADS = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLAIMS  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_UNSAFE     = 3'd2,
    ST_BAD_THREAD = 3'd3,
    ST_ZERO       = 3'd4,
    ST_OVER_NEED  = 3'd5,
    ST_OVER_ALLOC = 3'd6,
    ST_SHUT_DOWN  = 3'd7
  } status_t;

  typedef logic [UNIT_BITS-1:0] unit_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [TID_BITS-1:0] thread;
    unit_t               amount;
  } item_t;

  typedef struct packed {
    status_t status;
    unit_t   available_now;
    unit_t   thread_allocation;
    unit_t   thread_need;
  } result_t;

  // classified command as it sits in the queue
  typedef struct packed {
    item_t item;
    logic  bad_thread;
    logic  zero_amount;
  } entry_t;

  typedef struct packed {
    unit_t                    total_units;
    logic [THREADS_BITS-1:0]  active_threads;
    logic [CFG_DATA_BITS-1:0] claim_bytes;
  } cfg_t;

endpackage

>>> hw/rtl/bsra_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
module bsra_front
  import bsra_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  item_t                   item,
  input  logic [THREADS_BITS-1:0] active_threads,
  input  logic                    hold,
  output logic                    q_valid,
  output entry_t                  q_entry,
  input  logic                    q_pop
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  entry_t     entry_in;

  assign busy    = (count == 2'd2) || hold;
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_entry = mem[rd_ptr];

  always_comb begin
    entry_in.item        = item;
    entry_in.bad_thread  = ({1'b0, item.thread} >= active_threads);
    entry_in.zero_amount = (item.amount == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= entry_in;
        wr_ptr      <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

>>> hw/rtl/bsra_back.sv
// Back end: runs checks, tentative grant and the safety fixed point, and reports.
module bsra_back
  import bsra_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    reload,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  entry_t  q_entry,
  output logic    q_pop,
  output logic    done,
  output result_t result
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SAFE, S_REPLY} state_t;

  state_t                  state;
  entry_t                  cur;
  status_t                 status;
  unit_t                   avail;
  unit_t                   alloc [THREAD_SLOTS];
  unit_t                   need  [THREAD_SLOTS];
  logic                    shut;
  logic [THREAD_SLOTS-1:0] done_mask;
  logic [WORK_BITS-1:0]    work;

  logic [THREAD_SLOTS-1:0] live;
  logic [THREAD_SLOTS-1:0] fin;
  logic [WORK_BITS-1:0]    gain;
  logic                    all_done;
  logic [TID_BITS-1:0]     tid;
  unit_t                   amt;
  status_t                 exec_status;
  logic                    grant;
  logic                    give_back;

  assign tid   = cur.item.thread;
  assign amt   = cur.item.amount;
  assign q_pop = (state == S_IDLE) && q_valid && !reload;

  // checks in priority order; grant or give back only when all pass
  always_comb begin
    exec_status = ST_OK;
    grant       = 1'b0;
    give_back   = 1'b0;
    if (cur.item.command == CMD_REQUEST || cur.item.command == CMD_RELEASE) begin
      if (cur.bad_thread) begin
        exec_status = ST_BAD_THREAD;
      end else if (cur.zero_amount) begin
        exec_status = ST_ZERO;
      end else if (cur.item.command == CMD_REQUEST) begin
        if (amt > need[tid]) begin
          exec_status = ST_OVER_NEED;
        end else if (shut) begin
          exec_status = ST_SHUT_DOWN;
        end else if (amt > avail) begin
          exec_status = ST_SHORT;
        end else begin
          grant = 1'b1;
        end
      end else begin
        if (amt > alloc[tid]) begin
          exec_status = ST_OVER_ALLOC;
        end else begin
          give_back = 1'b1;
        end
      end
    end
  end

  // one pass of the safety check: every live thread whose need fits finishes
  always_comb begin
    gain = '0;
    for (int t = 0; t < THREAD_SLOTS; t++) begin
      live[t] = ({1'b0, TID_BITS'(t)} < cfg.active_threads);
      fin[t]  = live[t] && !done_mask[t] && ({{TID_BITS{1'b0}}, need[t]} <= work);
      if (fin[t]) begin
        gain = gain + {{TID_BITS{1'b0}}, alloc[t]};
      end
    end
    all_done = &(done_mask | ~live);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else if (reload) begin
      state <= S_IDLE;
      done  <= 1'b0;
      avail <= cfg.total_units;
      shut  <= 1'b0;
      for (int t = 0; t < THREAD_SLOTS; t++) begin
        alloc[t] <= '0;
        need[t]  <= (cfg.claim_bytes[8*t +: 8] > cfg.total_units) ?
                    cfg.total_units : cfg.claim_bytes[8*t +: 8];
      end
    end else begin
      done <= (state == S_REPLY);
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur   <= q_entry;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= exec_status;
          if (grant) begin
            // grant tentatively, then prove safety
            avail      <= avail - amt;
            alloc[tid] <= alloc[tid] + amt;
            need[tid]  <= need[tid] - amt;
            work       <= {{TID_BITS{1'b0}}, avail - amt};
            done_mask  <= '0;
            state      <= S_SAFE;
          end else begin
            if (give_back) begin
              avail      <= avail + amt;
              alloc[tid] <= alloc[tid] - amt;
              need[tid]  <= need[tid] + amt;
            end
            state <= S_REPLY;
          end
          if (cur.item.command == CMD_SHUTDOWN) begin
            shut <= 1'b1;
          end
        end
        S_SAFE: begin
          if (fin == '0) begin
            if (!all_done) begin
              // roll back the tentative grant
              avail      <= avail + amt;
              alloc[tid] <= alloc[tid] - amt;
              need[tid]  <= need[tid] + amt;
              status     <= ST_UNSAFE;
            end
            state <= S_REPLY;
          end else begin
            done_mask <= done_mask | fin;
            work      <= work + gain;
          end
        end
        S_REPLY: begin
          result.status            <= status;
          result.available_now     <= avail;
          result.thread_allocation <= cur.bad_thread ? '0 : alloc[tid];
          result.thread_need       <= cur.bad_thread ? '0 : need[tid];
          state                    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/bankers_single_resource_allocator.sv
// Top level of the single-resource banker's allocator: config registers, front, back.
// With the back end idle, an accepted command is queued, popped into the back end,
//   checked in S_EXEC and reported from S_REPLY; a request that passes its checks
//   first runs safety passes in S_SAFE until no further thread can finish.
// The back end takes one command at a time through its states; a two-entry queue
//   lets start be taken while the back end works.
// Reset and every write to a mapped index reload the accounting state; busy stays high
//   while that reload is pending. The receiver cannot stall: done is a one-cycle strobe.
module bankers_single_resource_allocator
  import bsra_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  item_t                     item,
  output logic                      done,
  output result_t                   result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // Configuration registers; reload_pend asks the back end to rebuild its
  // tables from them on the next edge and blocks new commands meanwhile.
  cfg_t   cfg;
  logic   reload_pend;

  // queue between front and back
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_units    <= 8'd255;
      cfg.active_threads <= 4'd8;
      cfg.claim_bytes    <= '0;
      reload_pend        <= 1'b1;
    end else begin
      // only writes to mapped indexes reload the tables
      reload_pend <= cfg_we && (cfg_index == REG_TOTAL || cfg_index == REG_THREADS ||
                                cfg_index == REG_CLAIMS);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TOTAL: begin
            cfg.total_units <= cfg_data[UNIT_BITS-1:0];
          end
          REG_THREADS: begin
            cfg.active_threads <= cfg_data[THREADS_BITS-1:0];
          end
          REG_CLAIMS: begin
            cfg.claim_bytes <= cfg_data;
          end
          default: begin
            // drop writes to unmapped indexes
          end
        endcase
      end
    end
  end

  // Front: classify bad thread and zero amount at accept time, queue the beat.
  bsra_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item),
    .active_threads (cfg.active_threads),
    .hold           (reload_pend),
    .q_valid        (q_valid),
    .q_entry        (q_entry),
    .q_pop          (q_pop)
  );

  // Back: state-dependent checks, tentative grant, safety passes, report.
  bsra_back u_back (
    .clk     (clk),
    .rst     (rst),
    .reload  (reload_pend),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

  // A result strobe never lasts more than one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe held for more than one cycle");

  // A bad thread reports zero allocation and need.
  a_bad_thread_zero: assert property (@(posedge clk) disable iff (rst)
      (done && result.status == ST_BAD_THREAD) |->
      (result.thread_allocation == '0 && result.thread_need == '0))
    else $error("bad thread result carries table values");

  // Coming out of reset the tables are rebuilt: no result, no command taken.
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> (busy && !done))
    else $error("activity in the cycle after reset");

endmodule
